FILE: rtl/gpio_bank_with_interrupts_top_macros.svh
// ----------------------------------------------------------------------------
// GPIO bank assertion macros
// Shared concurrent assertion forms for the GPIO bank RTL.
// ----------------------------------------------------------------------------
`ifndef GPIO_BANK_WITH_INTERRUPTS_TOP_MACROS_SVH
`define GPIO_BANK_WITH_INTERRUPTS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gbi_pkg.sv
// ----------------------------------------------------------------------------
// GPIO bank package
// Word types, command codes, register identifiers and address map constants.
// ----------------------------------------------------------------------------
package gbi_pkg;

    // Command codes carried by an input word.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Decoded register identifiers.
    typedef enum logic [3:0] {
        REG_NONE, REG_DR, REG_DDR, REG_EN, REG_MASK, REG_TYPE, REG_POL,
        REG_BOTH, REG_DEB, REG_STAT, REG_RAW, REG_EOI, REG_EXT
    } t_reg_id;

    // Register map modes.
    localparam logic MODE_FULL  = 1'b0;
    localparam logic MODE_SPLIT = 1'b1;

    // Full-word layout offsets.
    localparam logic [6:0] A0_DR   = 7'h00;
    localparam logic [6:0] A0_DDR  = 7'h04;
    localparam logic [6:0] A0_EN   = 7'h30;
    localparam logic [6:0] A0_MASK = 7'h34;
    localparam logic [6:0] A0_TYPE = 7'h38;
    localparam logic [6:0] A0_POL  = 7'h3c;
    localparam logic [6:0] A0_STAT = 7'h40;
    localparam logic [6:0] A0_RAW  = 7'h44;
    localparam logic [6:0] A0_DEB  = 7'h48;
    localparam logic [6:0] A0_EOI  = 7'h4c;
    localparam logic [6:0] A0_EXT  = 7'h50;

    // Split half-word layout base offsets.
    localparam logic [6:0] A1_DR   = 7'h00;
    localparam logic [6:0] A1_DDR  = 7'h08;
    localparam logic [6:0] A1_EN   = 7'h10;
    localparam logic [6:0] A1_MASK = 7'h18;
    localparam logic [6:0] A1_TYPE = 7'h20;
    localparam logic [6:0] A1_POL  = 7'h28;
    localparam logic [6:0] A1_BOTH = 7'h30;
    localparam logic [6:0] A1_DEB  = 7'h38;
    localparam logic [6:0] A1_STAT = 7'h50;
    localparam logic [6:0] A1_RAW  = 7'h58;
    localparam logic [6:0] A1_EOI  = 7'h60;
    localparam logic [6:0] A1_EXT  = 7'h70;

    // One accepted input word.
    typedef struct packed {
        t_cmd        command;
        logic [6:0]  address;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pin_drive;
        logic [31:0] pin_direction;
        logic        interrupt_request;
    } t_result;

endpackage

FILE: rtl/gbi_if.sv
// ----------------------------------------------------------------------------
// GPIO bank channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface gbi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  address;
    logic [31:0] write_data;
    logic [31:0] pin_levels;

    modport source (output valid, command, address, write_data, pin_levels,
                    input ready);
    modport sink   (input valid, command, address, write_data, pin_levels,
                    output ready);
endinterface

interface gbi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] pin_drive;
    logic [31:0] pin_direction;
    logic        interrupt_request;

    modport source (output valid, read_data, pin_drive, pin_direction,
                    interrupt_request, input ready);
    modport sink   (input valid, read_data, pin_drive, pin_direction,
                    interrupt_request, output ready);
endinterface

FILE: rtl/gbi_in_stage.sv
// ----------------------------------------------------------------------------
// GPIO bank input stage
// Registers one input word and hands it to the register file.
// ----------------------------------------------------------------------------
module gbi_in_stage
    import gbi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    gbi_in_if.sink i_in,
    input  logic  i_advance,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // A new word is taken when the stage is empty or its word moves on now.
    assign i_in.ready = !r_valid || i_advance;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command    <= t_cmd'(i_in.command);
            r_item.address    <= i_in.address;
            r_item.write_data <= i_in.write_data;
            r_item.pin_levels <= i_in.pin_levels;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: rtl/gbi_core.sv
// ----------------------------------------------------------------------------
// GPIO bank register file
// Pin registers and interrupt status; applies one word per cycle on i_fire.
// ----------------------------------------------------------------------------
`include "gpio_bank_with_interrupts_top_macros.svh"

module gbi_core
    import gbi_pkg::*;
#(
    parameter int PIN_COUNT = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int PW = PIN_COUNT;

    logic          r_mode;
    logic [PW-1:0] r_drive, r_dir, r_en, r_mask, r_type, r_pol, r_both, r_deb;
    logic [PW-1:0] r_raw, r_prev;
    logic [PW-1:0] n_drive, n_dir, n_en, n_mask, n_type, n_pol, n_both, n_deb;
    logic [PW-1:0] n_raw, n_prev;

    logic [6:0]    word_addr;
    logic [6:0]    split_base;
    logic          half;
    t_reg_id       reg_id;
    logic [31:0]   full_val;
    logic [31:0]   rd_val;
    logic [31:0]   en32, dat32;
    logic [PW-1:0] wen, wdat;
    logic [PW-1:0] eoi_clear;
    logic          is_eoi_write;
    logic [PW-1:0] now, rise, fall, hit, lvl;

    // Address decode for both layouts.
    assign word_addr  = {i_item.address[6:2], 2'b00};
    assign split_base = {i_item.address[6:3], 3'b000};
    assign half       = (r_mode == MODE_SPLIT) ? i_item.address[2] : 1'b0;

    always_comb begin
        reg_id = REG_NONE;
        if (r_mode == MODE_FULL) begin
            case (word_addr)
                A0_DR:   reg_id = REG_DR;
                A0_DDR:  reg_id = REG_DDR;
                A0_EN:   reg_id = REG_EN;
                A0_MASK: reg_id = REG_MASK;
                A0_TYPE: reg_id = REG_TYPE;
                A0_POL:  reg_id = REG_POL;
                A0_STAT: reg_id = REG_STAT;
                A0_RAW:  reg_id = REG_RAW;
                A0_DEB:  reg_id = REG_DEB;
                A0_EOI:  reg_id = REG_EOI;
                A0_EXT:  reg_id = REG_EXT;
                default: reg_id = REG_NONE;
            endcase
        end else begin
            case (split_base)
                A1_DR:   reg_id = REG_DR;
                A1_DDR:  reg_id = REG_DDR;
                A1_EN:   reg_id = REG_EN;
                A1_MASK: reg_id = REG_MASK;
                A1_TYPE: reg_id = REG_TYPE;
                A1_POL:  reg_id = REG_POL;
                A1_BOTH: reg_id = REG_BOTH;
                A1_DEB:  reg_id = REG_DEB;
                A1_STAT: reg_id = REG_STAT;
                A1_RAW:  reg_id = REG_RAW;
                A1_EOI:  reg_id = REG_EOI;
                A1_EXT:  reg_id = REG_EXT;
                default: reg_id = REG_NONE;
            endcase
        end
    end

    // Read mux; the split layout returns the selected half in the low bits.
    always_comb begin
        case (reg_id)
            REG_DR:   full_val = 32'(r_drive);
            REG_DDR:  full_val = 32'(r_dir);
            REG_EN:   full_val = 32'(r_en);
            REG_MASK: full_val = 32'(r_mask);
            REG_TYPE: full_val = 32'(r_type);
            REG_POL:  full_val = 32'(r_pol);
            REG_BOTH: full_val = 32'(r_both);
            REG_DEB:  full_val = 32'(r_deb);
            REG_STAT: full_val = 32'(r_raw & r_en & ~r_mask);
            REG_RAW:  full_val = 32'(r_raw);
            REG_EXT:  full_val = 32'(r_prev);
            default:  full_val = '0;
        endcase
        if (r_mode == MODE_FULL) begin
            rd_val = full_val;
        end else if (half) begin
            rd_val = {16'h0000, full_val[31:16]};
        end else begin
            rd_val = {16'h0000, full_val[15:0]};
        end
    end

    // Write enables and data; the split layout takes enables from the top half.
    always_comb begin
        if (r_mode == MODE_FULL) begin
            en32  = '1;
            dat32 = i_item.write_data;
        end else if (half) begin
            en32  = {i_item.write_data[31:16], 16'h0000};
            dat32 = {i_item.write_data[15:0], 16'h0000};
        end else begin
            en32  = {16'h0000, i_item.write_data[31:16]};
            dat32 = {16'h0000, i_item.write_data[15:0]};
        end
    end

    assign wen          = en32[PW-1:0];
    assign wdat         = dat32[PW-1:0];
    assign eoi_clear    = wdat & wen & r_type;
    assign is_eoi_write = (i_item.command == CMD_WRITE) && (reg_id == REG_EOI);

    // Edge and level detection for a sample tick.
    assign now  = i_item.pin_levels[PW-1:0];
    assign rise = now & ~r_prev;
    assign fall = r_prev & ~now;
    assign hit  = (rise & r_pol) | (fall & ~r_pol) | ((rise | fall) & r_both);
    assign lvl  = ~(now ^ r_pol);

    // Next-state logic for the whole register file.
    always_comb begin
        n_drive = r_drive;
        n_dir   = r_dir;
        n_en    = r_en;
        n_mask  = r_mask;
        n_type  = r_type;
        n_pol   = r_pol;
        n_both  = r_both;
        n_deb   = r_deb;
        n_raw   = r_raw;
        n_prev  = r_prev;
        case (i_item.command)
            CMD_WRITE: begin
                case (reg_id)
                    REG_DR:   n_drive = (r_drive & ~wen) | (wdat & wen);
                    REG_DDR:  n_dir   = (r_dir & ~wen) | (wdat & wen);
                    REG_EN:   n_en    = (r_en & ~wen) | (wdat & wen);
                    REG_MASK: n_mask  = (r_mask & ~wen) | (wdat & wen);
                    REG_TYPE: n_type  = (r_type & ~wen) | (wdat & wen);
                    REG_POL:  n_pol   = (r_pol & ~wen) | (wdat & wen);
                    REG_BOTH: n_both  = (r_both & ~wen) | (wdat & wen);
                    REG_DEB:  n_deb   = (r_deb & ~wen) | (wdat & wen);
                    REG_EOI:  n_raw   = r_raw & ~eoi_clear;
                    default:  n_raw   = r_raw;
                endcase
            end
            CMD_TICK: begin
                n_raw  = ((r_raw | hit) & r_type) | (lvl & ~r_type);
                n_prev = now;
            end
            default: begin
                n_raw = r_raw;
            end
        endcase
    end

    // Result word from the post-update state.
    always_comb begin
        o_result.read_data         = (i_item.command == CMD_READ) ? rd_val : '0;
        o_result.pin_drive         = 32'(n_drive);
        o_result.pin_direction     = 32'(n_dir);
        o_result.interrupt_request = |(n_raw & n_en & ~n_mask);
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // State registers, updated once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
            r_dir   <= '0;
            r_en    <= '0;
            r_mask  <= '0;
            r_type  <= '0;
            r_pol   <= '0;
            r_both  <= '0;
            r_deb   <= '0;
            r_raw   <= '0;
            r_prev  <= '0;
        end else if (i_fire) begin
            r_drive <= n_drive;
            r_dir   <= n_dir;
            r_en    <= n_en;
            r_mask  <= n_mask;
            r_type  <= n_type;
            r_pol   <= n_pol;
            r_both  <= n_both;
            r_deb   <= n_deb;
            r_raw   <= n_raw;
            r_prev  <= n_prev;
        end
    end

    // An end-of-interrupt write leaves none of the acknowledged edge bits set.
    `GBI_ASSERT_NEXT(a_eoi_clears, i_clk, i_rst_n, i_fire && is_eoi_write, (r_raw & $past(eoi_clear)) == '0, "EOI left an edge bit set")
    // After a tick, level-type status bits follow the pin against polarity.
    `GBI_ASSERT_NEXT(a_level_follow, i_clk, i_rst_n, i_fire && (i_item.command == CMD_TICK), ((r_raw ^ ~(r_prev ^ r_pol)) & ~r_type) == '0, "level status mismatch")
    // Only bus reads return data.
    `GBI_ASSERT_NOW(a_read_only_data, i_clk, i_rst_n, i_fire && (i_item.command != CMD_READ), o_result.read_data == '0, "read data on non-read word")

endmodule

FILE: rtl/gbi_out_stage.sv
// ----------------------------------------------------------------------------
// GPIO bank output stage
// Result register that holds a word until the sink takes it.
// ----------------------------------------------------------------------------
module gbi_out_stage
    import gbi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_result  i_result,
    output logic     o_load_ok,
    gbi_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // The register may be loaded when empty or being emptied this cycle.
    assign o_load_ok = !r_valid || o_out.ready;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_valid <= i_load;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.read_data         = r_result.read_data;
    assign o_out.pin_drive         = r_result.pin_drive;
    assign o_out.pin_direction     = r_result.pin_direction;
    assign o_out.interrupt_request = r_result.interrupt_request;

endmodule

FILE: rtl/gpio_bank_with_interrupts_top.sv
// ----------------------------------------------------------------------------
// GPIO bank with interrupts, top level
// Channel   Dir  Payload
// i_in      in   command, address, write_data, pin_levels
// o_out     out  read_data, pin_drive, pin_direction, interrupt_request
// i_cfg_*   in   register_map_mode (write enable, one data bit)
//
// One word is accepted per cycle while the result register is not stalled. Its
// result is loaded into the result register once that register is free.
// The register file update between them is combinational bitwise logic.
// Synchronous active-low reset clears the valid flags, register file and mode.
// A stalled result holds the input register, which then holds the input.
// ----------------------------------------------------------------------------
module gpio_bank_with_interrupts_top
    import gbi_pkg::*;
#(
    parameter int PIN_COUNT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    gbi_in_if.sink    i_in,
    gbi_out_if.source o_out
);

    logic    item_valid;
    t_item   item;
    logic    load_ok;
    logic    fire;
    t_result result;

    // A word is processed when it is present and the result register is free.
    assign fire = item_valid && load_ok;

    gbi_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_advance    (load_ok),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    gbi_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (item),
        .o_result    (result)
    );

    gbi_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (item_valid),
        .i_result  (result),
        .o_load_ok (load_ok),
        .o_out     (o_out)
    );

endmodule
